// ===== rtl/led_matrix_bitplane_scan_driver_assert.svh =====
// Assertion macros for the LED matrix bit-plane scan driver.
`ifndef LED_MATRIX_BITPLANE_SCAN_DRIVER_ASSERT_SVH
`define LED_MATRIX_BITPLANE_SCAN_DRIVER_ASSERT_SVH
`ifndef SYNTHESIS
`define LMBSD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lmbsd: assertion failed");
`define LMBSD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lmbsd: assertion failed");
`else
`define LMBSD_ASSERT_IMP(label, ante, cons)
`define LMBSD_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/lmbsd_pkg.sv =====
// Shared types and constants of the LED matrix bit-plane scan driver.
package lmbsd_pkg;

	localparam int PANEL_WIDTH_DEF  = 64;
	localparam int SCAN_ROWS_DEF    = 16;
	localparam int COLOR_BITS_DEF   = 4;
	localparam int PALETTE_SIZE_DEF = 256;

	localparam int OP_W       = 3;
	localparam int SLOT_W     = 8;
	localparam int RGB_W      = 16;
	localparam int X_W        = 6;
	localparam int Y_W        = 5;
	localparam int IDX_W      = 8;
	localparam int SLOT_LSB   = 0;
	localparam int RGB_LSB    = SLOT_LSB + SLOT_W;
	localparam int X_LSB      = RGB_LSB + RGB_W;
	localparam int Y_LSB      = X_LSB + X_W;
	localparam int IDX_LSB    = Y_LSB + Y_W;
	localparam int IN_DATA_W  = 48;

	localparam int ROW_ADDR_W = 4;
	localparam int OUT_PAD_W  = 3;
	localparam int OUT_DATA_W = 16;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int BASE_W     = 16;

	typedef enum logic [OP_W-1:0] {
		OP_PALETTE = 3'd0,
		OP_PIXEL   = 3'd1,
		OP_COMMIT  = 3'd2,
		OP_TICK    = 3'd3,
		OP_START   = 3'd4,
		OP_STOP    = 3'd5
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_PERIOD = 1'b0,
		REG_SWAP_GB     = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_PIX_WR,
		ST_SHIFT,
		ST_STOP
	} state_t;

endpackage

// ===== rtl/lmbsd_ram.sv =====
// Generic simple dual-port RAM with registered read.
module lmbsd_ram #(
	parameter int WIDTH = 3 * lmbsd_pkg::COLOR_BITS_DEF,
	parameter int DEPTH = lmbsd_pkg::PALETTE_SIZE_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/lmbsd_quant.sv =====
// RGB565 to rounded per-channel levels for palette entries.
module lmbsd_quant #(
	parameter int COLOR_BITS = lmbsd_pkg::COLOR_BITS_DEF
) (
	input  logic [lmbsd_pkg::RGB_W-1:0] rgb565,
	input  logic                        swap_green_blue,
	output logic [3*COLOR_BITS-1:0]     levels
);
	import lmbsd_pkg::*;

	localparam int LW     = COLOR_BITS;
	localparam int NUM_W  = 14;
	localparam int MUL_W  = 15;
	localparam int PROD_W = NUM_W + MUL_W;
	localparam int SHIFT5 = 18;
	localparam int SHIFT6 = 20;
	localparam logic [NUM_W-1:0] LEVEL_MAX = NUM_W'((1 << LW) - 1);
	localparam logic [NUM_W-1:0] HALF5  = 14'd15;
	localparam logic [NUM_W-1:0] HALF6  = 14'd31;
	// reciprocals of 31 and 63, exact over the whole numerator range
	localparam logic [MUL_W-1:0] RECIP5 = 15'd8457;
	localparam logic [MUL_W-1:0] RECIP6 = 15'd16645;

	logic [NUM_W-1:0]  red_num;
	logic [NUM_W-1:0]  green_num;
	logic [NUM_W-1:0]  blue_num;
	logic [PROD_W-1:0] red_prod;
	logic [PROD_W-1:0] green_prod;
	logic [PROD_W-1:0] blue_prod;
	logic [LW-1:0]     red_lv;
	logic [LW-1:0]     green_lv;
	logic [LW-1:0]     blue_lv;

	always_comb begin
		red_num    = NUM_W'(rgb565[15:11]) * LEVEL_MAX + HALF5;
		green_num  = NUM_W'(rgb565[10:5]) * LEVEL_MAX + HALF6;
		blue_num   = NUM_W'(rgb565[4:0]) * LEVEL_MAX + HALF5;
		red_prod   = PROD_W'(red_num) * PROD_W'(RECIP5);
		green_prod = PROD_W'(green_num) * PROD_W'(RECIP6);
		blue_prod  = PROD_W'(blue_num) * PROD_W'(RECIP5);
		red_lv     = red_prod[SHIFT5 +: LW];
		green_lv   = green_prod[SHIFT6 +: LW];
		blue_lv    = blue_prod[SHIFT5 +: LW];
		levels     = swap_green_blue ? {red_lv, blue_lv, green_lv}
		                             : {red_lv, green_lv, blue_lv};
	end

endmodule

// ===== rtl/led_matrix_bitplane_scan_driver.sv =====
// Top level of the LED matrix bit-plane scan driver.
// A refresh reads each column from the frame memory into a read stage, then into the output register;
// columns leave one per cycle, paced by the frame memory read port, unless m_axis_tready stalls the output.
// Items are taken only in idle: a pixel write reads both memories, then writes, and stop waits for the output.
// Reset: control state clears at once; a sweep then zeroes both memories over
// max(2^(1+clog2(SCAN_ROWS)+clog2(PANEL_WIDTH)), PALETTE_SIZE) addresses (2048 by default).
`include "led_matrix_bitplane_scan_driver_assert.svh"
module led_matrix_bitplane_scan_driver #(
	parameter int PANEL_WIDTH  = lmbsd_pkg::PANEL_WIDTH_DEF,
	parameter int SCAN_ROWS    = lmbsd_pkg::SCAN_ROWS_DEF,
	parameter int COLOR_BITS   = lmbsd_pkg::COLOR_BITS_DEF,
	parameter int PALETTE_SIZE = lmbsd_pkg::PALETTE_SIZE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// palette_slot, rgb565, pixel_x, pixel_y, pixel_color_index
	input  logic [lmbsd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// op
	input  logic [lmbsd_pkg::OP_W-1:0]       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// upper_rgb, lower_rgb, row_address, clock_pulse, latch, blank
	output logic [lmbsd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                             m_axis_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lmbsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lmbsd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lmbsd_pkg::*;

	localparam int LW          = COLOR_BITS;
	localparam int PIX_W       = 3 * LW;
	localparam int WORD_W      = 2 * PIX_W;
	localparam int CW          = $clog2(PANEL_WIDTH);
	localparam int RW          = $clog2(SCAN_ROWS);
	localparam int PL_W        = (COLOR_BITS > 1) ? $clog2(COLOR_BITS) : 1;
	localparam int FA_W        = 1 + RW + CW;
	localparam int FRAME_DEPTH = 1 << FA_W;
	localparam int PA_W        = $clog2(PALETTE_SIZE);
	localparam int CLR_DEPTH   = (FRAME_DEPTH > PALETTE_SIZE) ? FRAME_DEPTH : PALETTE_SIZE;
	localparam int CLR_W       = $clog2(CLR_DEPTH);
	localparam int PER_W       = BASE_W + 1;
	localparam int CNT_W       = PER_W + COLOR_BITS - 1;

	function automatic logic [2:0] plane_bits(input logic [PIX_W-1:0] w,
			input logic [PL_W-1:0] p);
		logic [LW-1:0] r;
		logic [LW-1:0] g;
		logic [LW-1:0] b;
		r = w[3*LW-1:2*LW];
		g = w[2*LW-1:LW];
		b = w[LW-1:0];
		return {r[p], g[p], b[p]};
	endfunction

	state_t state_q, state_d;

	op_t                op_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [RGB_W-1:0]   rgb_q;
	logic [X_W-1:0]     x_q;
	logic [Y_W-1:0]     y_q;
	logic [IDX_W-1:0]   idx_q;

	logic [BASE_W-1:0]  base_q;
	logic               sgb_q;
	logic               active_q;
	logic               pending_q;
	logic               running_q;
	logic [RW-1:0]      row_q;
	logic [PL_W-1:0]    plane_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CLR_W-1:0]   clr_q;

	logic [RW-1:0]      ref_row_q;
	logic [PL_W-1:0]    ref_plane_q;
	logic [CW-1:0]      col_q;
	logic               issue_done_q;
	logic               rd_s1;
	logic [CW-1:0]      col_s1;

	logic               out_valid_q;
	logic [2:0]         out_upper_q;
	logic [2:0]         out_lower_q;
	logic [ROW_ADDR_W-1:0] out_row_q;
	logic               out_clk_q;
	logic               out_latch_q;
	logic               out_blank_q;
	logic               out_last_q;

	logic               frame_we;
	logic [FA_W-1:0]    frame_waddr;
	logic [WORD_W-1:0]  frame_wdata;
	logic               frame_re;
	logic [FA_W-1:0]    frame_raddr;
	logic [WORD_W-1:0]  frame_rdata;
	logic               pal_we;
	logic [PA_W-1:0]    pal_waddr;
	logic [PIX_W-1:0]   pal_wdata;
	logic               pal_re;
	logic [PA_W-1:0]    pal_raddr;
	logic [PIX_W-1:0]   pal_rdata;
	logic [PIX_W-1:0]   levels;

	logic               pix_half;
	logic [Y_W-1:0]     pix_row;
	logic [FA_W-1:0]    pix_addr;
	logic               pix_ok;
	logic [WORD_W-1:0]  pix_merged;

	logic [RW-1:0]      ref_row_d;
	logic [PL_W-1:0]    ref_plane_d;
	logic               swap_now;
	logic [PER_W-1:0]   period;
	logic [CNT_W-1:0]   cnt_load;
	logic               plane_last;
	logic               row_last;
	logic               tick_fire;
	logic               do_ref;

	logic               out_free;
	logic               col_load;
	logic               col_issue;
	logic               stop_load;
	logic               out_load;

	lmbsd_quant #(
		.COLOR_BITS(COLOR_BITS)
	) u_quant (
		.rgb565         (rgb_q),
		.swap_green_blue(sgb_q),
		.levels         (levels)
	);

	lmbsd_ram #(
		.WIDTH(WORD_W),
		.DEPTH(FRAME_DEPTH)
	) u_frame_ram (
		.clk  (clk),
		.we   (frame_we),
		.waddr(frame_waddr),
		.wdata(frame_wdata),
		.re   (frame_re),
		.raddr(frame_raddr),
		.rdata(frame_rdata)
	);

	lmbsd_ram #(
		.WIDTH(PIX_W),
		.DEPTH(PALETTE_SIZE)
	) u_palette_ram (
		.clk  (clk),
		.we   (pal_we),
		.waddr(pal_waddr),
		.wdata(pal_wdata),
		.re   (pal_re),
		.raddr(pal_raddr),
		.rdata(pal_rdata)
	);

	always_comb begin
		pix_half   = 6'(y_q) >= 6'(SCAN_ROWS);
		pix_row    = pix_half ? (y_q - Y_W'(SCAN_ROWS)) : y_q;
		pix_addr   = {~active_q, pix_row[RW-1:0], x_q[CW-1:0]};
		pix_ok     = !pending_q && (7'(x_q) < 7'(PANEL_WIDTH))
		             && (6'(y_q) < 6'(2 * SCAN_ROWS)) && (9'(idx_q) < 9'(PALETTE_SIZE));
		pix_merged = pix_half ? {frame_rdata[WORD_W-1:PIX_W], pal_rdata}
		                      : {pal_rdata, frame_rdata[PIX_W-1:0]};

		ref_row_d   = (op_q == OP_START) ? '0 : row_q;
		ref_plane_d = (op_q == OP_START) ? '0 : plane_q;
		swap_now    = pending_q && (ref_row_d == '0) && (ref_plane_d == '0);
		period      = PER_W'(base_q) + PER_W'(1);
		cnt_load    = CNT_W'(period) << ref_plane_d;
		plane_last  = ref_plane_d == PL_W'(COLOR_BITS - 1);
		row_last    = ref_row_d == RW'(SCAN_ROWS - 1);
		tick_fire   = running_q && (cnt_q <= CNT_W'(1));
		do_ref      = (state_q == ST_EXEC)
		              && (((op_q == OP_TICK) && tick_fire) || ((op_q == OP_START) && !running_q));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_W'(CLR_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (do_ref) begin
					state_d = ST_SHIFT;
				end else if (op_q == OP_PIXEL) begin
					state_d = ST_PIX_WR;
				end else if (op_q == OP_STOP) begin
					state_d = ST_STOP;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_PIX_WR: state_d = ST_IDLE;
			ST_SHIFT: begin
				if (col_load && (col_s1 == CW'(PANEL_WIDTH - 1))) begin
					state_d = ST_IDLE;
				end
			end
			ST_STOP: begin
				if (stop_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = state_q == ST_IDLE;
		out_free      = !out_valid_q || m_axis_tready;
		col_load      = (state_q == ST_SHIFT) && rd_s1 && out_free;
		col_issue     = (state_q == ST_SHIFT) && !issue_done_q && (!rd_s1 || col_load);
		stop_load     = (state_q == ST_STOP) && out_free;
		out_load      = col_load || stop_load;
		frame_we      = 1'b0;
		frame_waddr   = '0;
		frame_wdata   = '0;
		frame_re      = 1'b0;
		frame_raddr   = '0;
		pal_we        = 1'b0;
		pal_waddr     = '0;
		pal_wdata     = '0;
		pal_re        = 1'b0;
		pal_raddr     = '0;
		case (state_q)
			ST_CLEAR: begin
				frame_we    = 1'b1;
				frame_waddr = clr_q[FA_W-1:0];
				pal_we      = (CLR_W + 1)'(clr_q) < (CLR_W + 1)'(PALETTE_SIZE);
				pal_waddr   = clr_q[PA_W-1:0];
			end
			ST_EXEC: begin
				if ((op_q == OP_PALETTE) && (9'(slot_q) < 9'(PALETTE_SIZE))) begin
					pal_we    = 1'b1;
					pal_waddr = slot_q[PA_W-1:0];
					pal_wdata = levels;
				end
				if (op_q == OP_PIXEL) begin
					frame_re    = 1'b1;
					frame_raddr = pix_addr;
					pal_re      = 1'b1;
					pal_raddr   = idx_q[PA_W-1:0];
				end
			end
			ST_PIX_WR: begin
				frame_we    = pix_ok;
				frame_waddr = pix_addr;
				frame_wdata = pix_merged;
			end
			ST_SHIFT: begin
				frame_re    = col_issue;
				frame_raddr = {active_q, ref_row_q, col_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			base_q       <= '0;
			sgb_q        <= 1'b0;
			active_q     <= 1'b0;
			pending_q    <= 1'b0;
			running_q    <= 1'b0;
			row_q        <= '0;
			plane_q      <= '0;
			cnt_q        <= '0;
			col_q        <= '0;
			issue_done_q <= 1'b0;
			rd_s1        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (reg_idx_t'(cfg_index))
					REG_BASE_PERIOD: base_q <= cfg_data[BASE_W-1:0];
					REG_SWAP_GB:     sgb_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CLR_W'(1);
			end
			if (state_q == ST_EXEC) begin
				case (op_q)
					OP_COMMIT: begin
						if (running_q) begin
							pending_q <= 1'b1;
						end else begin
							active_q  <= ~active_q;
							pending_q <= 1'b0;
						end
					end
					OP_TICK: begin
						if (running_q && !tick_fire) begin
							cnt_q <= cnt_q - CNT_W'(1);
						end
					end
					OP_START: begin
						if (!running_q) begin
							running_q <= 1'b1;
						end
					end
					OP_STOP: running_q <= 1'b0;
					default: ;
				endcase
			end
			if (do_ref) begin
				if (swap_now) begin
					active_q  <= ~active_q;
					pending_q <= 1'b0;
				end
				cnt_q        <= cnt_load;
				plane_q      <= plane_last ? '0 : ref_plane_d + PL_W'(1);
				if (plane_last) begin
					row_q <= row_last ? '0 : ref_row_d + RW'(1);
				end else begin
					row_q <= ref_row_d;
				end
				col_q        <= '0;
				issue_done_q <= 1'b0;
			end
			if (col_issue) begin
				col_q <= col_q + CW'(1);
				if (col_q == CW'(PANEL_WIDTH - 1)) begin
					issue_done_q <= 1'b1;
				end
				rd_s1 <= 1'b1;
			end else if (col_load) begin
				rd_s1 <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_q   <= op_t'(s_axis_tuser);
			slot_q <= s_axis_tdata[SLOT_LSB +: SLOT_W];
			rgb_q  <= s_axis_tdata[RGB_LSB +: RGB_W];
			x_q    <= s_axis_tdata[X_LSB +: X_W];
			y_q    <= s_axis_tdata[Y_LSB +: Y_W];
			idx_q  <= s_axis_tdata[IDX_LSB +: IDX_W];
		end
		if (do_ref) begin
			ref_row_q   <= ref_row_d;
			ref_plane_q <= ref_plane_d;
		end
		if (col_issue) begin
			col_s1 <= col_q;
		end
		if (col_load) begin
			out_upper_q <= plane_bits(frame_rdata[WORD_W-1:PIX_W], ref_plane_q);
			out_lower_q <= plane_bits(frame_rdata[PIX_W-1:0], ref_plane_q);
			out_row_q   <= ROW_ADDR_W'(ref_row_q);
			out_clk_q   <= 1'b1;
			out_latch_q <= col_s1 == CW'(PANEL_WIDTH - 1);
			out_blank_q <= 1'b1;
			out_last_q  <= col_s1 == CW'(PANEL_WIDTH - 1);
		end else if (stop_load) begin
			out_upper_q <= '0;
			out_lower_q <= '0;
			out_row_q   <= '0;
			out_clk_q   <= 1'b0;
			out_latch_q <= 1'b0;
			out_blank_q <= 1'b1;
			out_last_q  <= 1'b1;
		end
	end

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_blank_q, out_latch_q, out_clk_q,
	                        out_row_q, out_lower_q, out_upper_q};

	`LMBSD_ASSERT_IMP(a_read_only_in_shift, rd_s1, state_q == ST_SHIFT)
	`LMBSD_ASSERT_IMP(a_pixel_to_back, (state_q == ST_PIX_WR) && frame_we, frame_waddr[FA_W-1] != active_q)
	`LMBSD_ASSERT_IMP(a_shift_ends_latched, ($past(state_q) == ST_SHIFT) && (state_q == ST_IDLE), out_valid_q && out_latch_q && out_last_q)
	`LMBSD_ASSERT_NXT(a_period_loaded, do_ref, cnt_q != '0)

endmodule
